// File: design/buoyancy_profile_evaluator_top_assert.svh
// Assertion macros shared by the checker of the buoyancy profile evaluator.
`ifndef BUOYANCY_PROFILE_EVALUATOR_TOP_ASSERT_SVH
`define BUOYANCY_PROFILE_EVALUATOR_TOP_ASSERT_SVH

// Checked at every clock edge outside reset.
`define BPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define BPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/bpe_pkg.sv
// Types and constants shared by the buoyancy profile evaluator modules.
package bpe_pkg;

  localparam int NUM_TABLES = 3;
  localparam int COUNT_W    = 5;
  localparam int DIV_STEPS  = 32;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [1:0] TBL_CLOUD = 2'd0;
  localparam logic [1:0] TBL_MIX   = 2'd1;
  localparam logic [1:0] TBL_SAT   = 2'd2;

  localparam logic [1:0] REG_FORCE_FACTOR = 2'd0;
  localparam logic [1:0] REG_CLOUD_COUNT  = 2'd1;
  localparam logic [1:0] REG_MIX_COUNT    = 2'd2;
  localparam logic [1:0] REG_SAT_COUNT    = 2'd3;

  localparam logic signed [31:0] FORCE_FACTOR_RESET = 32'sd65536;
  localparam logic [16:0]        C_ONE              = 17'h10000;

  typedef struct packed {
    logic               cmd;
    logic [1:0]         table_select;
    logic [3:0]         knot_index;
    logic signed [31:0] knot_height;
    logic signed [31:0] knot_value;
    logic signed [31:0] cell_height;
    logic signed [31:0] tracer_fraction;
  } bpe_in_t;

  typedef struct packed {
    logic signed [31:0] buoyancy;
    logic signed [31:0] force_increment;
    logic               table_empty;
  } bpe_out_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SCAN_RD, ST_SCAN_CMP, ST_FETCH_A, ST_FETCH_B, ST_SETUP, ST_STORE,
    ST_IMUL, ST_IPREP, ST_IGO, ST_IWAIT, ST_IDONE,
    ST_CSEL, ST_CA1, ST_CA2, ST_CACC, ST_CB, ST_CBLD, ST_CPREP, ST_CGO, ST_CWAIT,
    ST_CDONE, ST_FMUL, ST_FSAT, ST_EMIT
  } bpe_state_e;

  typedef enum logic [2:0] {
    MUL_INTERP, MUL_CA1, MUL_CA2, MUL_CB, MUL_FORCE
  } bpe_mul_sel_e;

  typedef enum logic {
    LUT_FROM_Y0, LUT_FROM_INTERP
  } bpe_lut_src_e;

  typedef enum logic [1:0] {
    B_FROM_CLOUD, B_FROM_ZERO, B_FROM_QUOT
  } bpe_b_src_e;

  typedef struct packed {
    logic         load_we;
    logic         eval_start;
    logic         eval_empty;
    logic         latch_lo;
    logic         interp_setup;
    logic         lut_we;
    bpe_lut_src_e lut_src;
    logic [1:0]   lut_sel;
    bpe_mul_sel_e mul_sel;
    logic         prod_en;
    logic         acc_load;
    logic         acc_add;
    logic         num_from_prod;
    logic         curve_prep;
    logic         seg_b;
    logic         div_start;
    logic         b_we;
    bpe_b_src_e   b_src;
    logic         force_we;
  } bpe_cmd_t;

  typedef struct packed {
    logic h_le_x;
    logic x0_lt_x1;
    logic c_zero;
    logic c_one;
    logic c_lt_chis;
    logic div_done;
  } bpe_status_t;

endpackage

// File: design/bpe_divider.sv
// Radix-2 restoring divider, 64 by 32 bits, for quotients known to fit 32 bits.
module bpe_divider import bpe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] qr_q, qr_d;
  logic [31:0] dvs_q, dvs_d;
  logic [32:0] trial;
  logic        ge;

  always_comb begin
    trial = {rem_q, qr_q[31]};
    ge    = trial >= {1'b0, dvs_q};
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    qr_d   = qr_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d = 6'(DIV_STEPS);
      rem_d = dividend_i[63:32];
      qr_d  = dividend_i[31:0];
      dvs_d = divisor_i;
    end else if (cnt_q != 6'd0) begin
      cnt_d  = cnt_q - 6'd1;
      done_d = (cnt_q == 6'd1);
      rem_d  = ge ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
      qr_d   = {qr_q[30:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    qr_q  <= qr_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = qr_q;

endmodule

// File: design/bpe_datapath.sv
// Datapath: knot memories, interpolation and curve arithmetic, result registers.
module bpe_datapath import bpe_pkg::*; #(
  parameter int TABLE_POINTS = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  bpe_cmd_t                                   cmd_i,
  input  logic [$clog2(NUM_TABLES*TABLE_POINTS)-1:0] rd_addr_i,
  input  bpe_in_t                                    in_item_i,
  input  logic signed [31:0]                         force_factor_i,
  output bpe_status_t                                status_o,
  output bpe_out_t                                   result_o
);

  localparam int Depth = NUM_TABLES * TABLE_POINTS;
  localparam int AW    = $clog2(Depth);

  logic signed [31:0] h_mem [Depth];
  logic signed [31:0] v_mem [Depth];
  logic signed [31:0] h_rd_q, v_rd_q;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;

  logic signed [31:0] x_q, x0_q, y0_q;
  logic [16:0]        c_q, c_clamp;
  logic [31:0]        mag_q, dx_q, den_q, mag_d;
  logic               neg_q;
  logic signed [31:0] lut_q [NUM_TABLES];
  logic signed [64:0] prod_q, acc_q;
  logic [63:0]        num_q;
  logic signed [31:0] b_q, f_q;
  logic               empty_q;

  logic signed [32:0] dy;
  logic [32:0]        dy_abs;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [64:0] acc_abs;
  logic signed [32:0] den_b;
  logic signed [31:0] chis;
  logic [31:0]        quot;
  logic               div_done;
  logic signed [31:0] interp_val, quot_val, b_d, f_d;
  logic signed [64:0] f_bias, f_shift;

  assign wr_en   = cmd_i.load_we && (32'(in_item_i.table_select) < NUM_TABLES)
                   && (32'(in_item_i.knot_index) < TABLE_POINTS);
  assign wr_addr = AW'(32'(in_item_i.table_select) * TABLE_POINTS
                       + 32'(in_item_i.knot_index));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      h_mem[wr_addr] <= in_item_i.knot_height;
      v_mem[wr_addr] <= in_item_i.knot_value;
    end
    h_rd_q <= h_mem[rd_addr_i];
    v_rd_q <= v_mem[rd_addr_i];
  end

  always_comb begin
    if (in_item_i.tracer_fraction[31]) begin
      c_clamp = '0;
    end else if (in_item_i.tracer_fraction > 32'sd65536) begin
      c_clamp = C_ONE;
    end else begin
      c_clamp = in_item_i.tracer_fraction[16:0];
    end
  end

  assign chis   = lut_q[TBL_MIX];
  assign dy     = {v_rd_q[31], v_rd_q} - {y0_q[31], y0_q};
  assign dy_abs = dy[32] ? 33'(-dy) : 33'(dy);
  assign mag_d  = dy_abs[31:0];
  assign den_b  = 33'sd65536 - {chis[31], chis};

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_INTERP: begin
        mul_a = {1'b0, mag_q};
        mul_b = {1'b0, dx_q};
      end
      MUL_CA1: begin
        mul_a = {lut_q[TBL_CLOUD][31], lut_q[TBL_CLOUD]};
        mul_b = {chis[31], chis} - {16'b0, c_q};
      end
      MUL_CA2: begin
        mul_a = {lut_q[TBL_SAT][31], lut_q[TBL_SAT]};
        mul_b = {16'b0, c_q};
      end
      MUL_CB: begin
        mul_a = {lut_q[TBL_SAT][31], lut_q[TBL_SAT]};
        mul_b = {16'b0, 17'(C_ONE - c_q)};
      end
      MUL_FORCE: begin
        mul_a = {b_q[31], b_q};
        mul_b = {force_factor_i[31], force_factor_i};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign acc_abs = acc_q[64] ? 65'(-acc_q) : acc_q;

  assign interp_val = neg_q ? 32'(y0_q - quot) : 32'(y0_q + quot);
  assign quot_val   = neg_q ? 32'(-quot) : quot;

  always_comb begin
    unique case (cmd_i.b_src)
      B_FROM_CLOUD: b_d = lut_q[TBL_CLOUD];
      B_FROM_ZERO:  b_d = '0;
      B_FROM_QUOT:  b_d = quot_val;
      default:      b_d = '0;
    endcase
  end

  assign f_bias  = prod_q + (prod_q[64] ? 65'sd65535 : 65'sd0);
  assign f_shift = f_bias >>> 16;

  always_comb begin
    if (f_shift > 65'sd2147483647) begin
      f_d = 32'sh7fffffff;
    end else if (f_shift < -65'sd2147483648) begin
      f_d = 32'sh80000000;
    end else begin
      f_d = f_shift[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_start) begin
      x_q     <= in_item_i.cell_height;
      c_q     <= c_clamp;
      empty_q <= cmd_i.eval_empty;
      if (cmd_i.eval_empty) begin
        b_q <= '0;
        f_q <= '0;
      end
    end
    if (cmd_i.latch_lo) begin
      x0_q <= h_rd_q;
      y0_q <= v_rd_q;
    end
    if (cmd_i.interp_setup) begin
      mag_q <= mag_d;
      neg_q <= dy[32];
      dx_q  <= 32'(x_q - x0_q);
      den_q <= 32'(h_rd_q - x0_q);
    end
    if (cmd_i.lut_we) begin
      lut_q[cmd_i.lut_sel] <= (cmd_i.lut_src == LUT_FROM_INTERP) ? interp_val : y0_q;
    end
    if (cmd_i.prod_en) begin
      prod_q <= mul_p[64:0];
    end
    if (cmd_i.acc_load) begin
      acc_q <= prod_q;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + prod_q;
    end
    if (cmd_i.num_from_prod) begin
      num_q <= prod_q[63:0];
    end else if (cmd_i.curve_prep) begin
      num_q <= acc_abs[63:0];
      neg_q <= acc_q[64];
      den_q <= cmd_i.seg_b ? den_b[31:0] : chis;
    end
    if (cmd_i.b_we) begin
      b_q <= b_d;
    end
    if (cmd_i.force_we) begin
      f_q <= f_d;
    end
  end

  bpe_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (num_q),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  always_comb begin
    status_o.h_le_x    = h_rd_q <= x_q;
    status_o.x0_lt_x1  = x0_q < h_rd_q;
    status_o.c_zero    = (c_q == '0);
    status_o.c_one     = (c_q == C_ONE);
    status_o.c_lt_chis = $signed({15'b0, c_q}) < chis;
    status_o.div_done  = div_done;
  end

  assign result_o.buoyancy        = b_q;
  assign result_o.force_increment = f_q;
  assign result_o.table_empty     = empty_q;

endmodule

// File: design/bpe_ctrl.sv
// Controller: sequences knot scans, interpolations, the curve and the force scaling.
module bpe_ctrl import bpe_pkg::*; #(
  parameter int TABLE_POINTS = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  input  logic                                       in_cmd_i,
  input  logic [COUNT_W-1:0]                         cloud_count_i,
  input  logic [COUNT_W-1:0]                         mix_count_i,
  input  logic [COUNT_W-1:0]                         sat_count_i,
  input  bpe_status_t                                status_i,
  output bpe_cmd_t                                   cmd_o,
  output logic [$clog2(NUM_TABLES*TABLE_POINTS)-1:0] rd_addr_o,
  output logic                                       busy_o,
  output logic                                       result_valid_o
);

  localparam int AW = $clog2(NUM_TABLES * TABLE_POINTS);
  localparam int KW = $clog2(TABLE_POINTS + 1);
  localparam int CW = (KW > COUNT_W) ? KW : COUNT_W;

  bpe_state_e     state_q, state_d;
  logic [1:0]     tbl_q, tbl_d;
  logic [KW-1:0]  k_q, k_d;
  logic           seg_b_q, seg_b_d;
  logic [COUNT_W-1:0] cnt_sel;
  logic [CW-1:0]  cnt_ext;
  logic [KW-1:0]  n;
  logic           empty;
  logic           advance;
  logic [31:0]    base, addr;

  always_comb begin
    unique case (tbl_q)
      TBL_CLOUD: cnt_sel = cloud_count_i;
      TBL_MIX:   cnt_sel = mix_count_i;
      default:   cnt_sel = sat_count_i;
    endcase
  end

  assign cnt_ext = CW'(cnt_sel);
  assign n       = (cnt_ext > CW'(TABLE_POINTS)) ? KW'(TABLE_POINTS) : KW'(cnt_ext);
  assign empty   = (cloud_count_i == '0) || (mix_count_i == '0) || (sat_count_i == '0);
  assign base    = 32'(tbl_q) * TABLE_POINTS;

  always_comb begin
    if (state_q == ST_FETCH_A && k_q != '0) begin
      addr = base + 32'(k_q) - 32'd1;
    end else begin
      addr = base + 32'(k_q);
    end
  end

  assign rd_addr_o = addr[AW-1:0];

  always_comb begin
    state_d = state_q;
    tbl_d   = tbl_q;
    k_d     = k_q;
    seg_b_d = seg_b_q;
    advance = 1'b0;
    cmd_o   = '0;
    cmd_o.lut_sel = tbl_q;
    cmd_o.seg_b   = seg_b_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (in_cmd_i == CMD_LOAD) begin
            cmd_o.load_we = 1'b1;
          end else begin
            cmd_o.eval_start = 1'b1;
            cmd_o.eval_empty = empty;
            tbl_d   = TBL_CLOUD;
            k_d     = '0;
            state_d = empty ? ST_EMIT : ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD:  state_d = (k_q == n) ? ST_FETCH_A : ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (status_i.h_le_x) begin
          k_d     = k_q + KW'(1);
          state_d = ST_SCAN_RD;
        end else begin
          state_d = ST_FETCH_A;
        end
      end
      ST_FETCH_A: state_d = ST_FETCH_B;
      ST_FETCH_B: begin
        cmd_o.latch_lo = 1'b1;
        state_d = (k_q == '0 || k_q == n) ? ST_STORE : ST_SETUP;
      end
      ST_SETUP: begin
        if (status_i.x0_lt_x1) begin
          cmd_o.interp_setup = 1'b1;
          state_d = ST_IMUL;
        end else begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.lut_we  = 1'b1;
        cmd_o.lut_src = LUT_FROM_Y0;
        advance = 1'b1;
      end
      ST_IMUL: begin
        cmd_o.mul_sel = MUL_INTERP;
        cmd_o.prod_en = 1'b1;
        state_d = ST_IPREP;
      end
      ST_IPREP: begin
        cmd_o.num_from_prod = 1'b1;
        state_d = ST_IGO;
      end
      ST_IGO: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_IWAIT;
      end
      ST_IWAIT: if (status_i.div_done) state_d = ST_IDONE;
      ST_IDONE: begin
        cmd_o.lut_we  = 1'b1;
        cmd_o.lut_src = LUT_FROM_INTERP;
        advance = 1'b1;
      end
      ST_CSEL: begin
        if (status_i.c_zero) begin
          cmd_o.b_we  = 1'b1;
          cmd_o.b_src = B_FROM_CLOUD;
          state_d = ST_FMUL;
        end else if (status_i.c_one) begin
          cmd_o.b_we  = 1'b1;
          cmd_o.b_src = B_FROM_ZERO;
          state_d = ST_FMUL;
        end else if (status_i.c_lt_chis) begin
          seg_b_d = 1'b0;
          state_d = ST_CA1;
        end else begin
          seg_b_d = 1'b1;
          state_d = ST_CB;
        end
      end
      ST_CA1: begin
        cmd_o.mul_sel = MUL_CA1;
        cmd_o.prod_en = 1'b1;
        state_d = ST_CA2;
      end
      ST_CA2: begin
        cmd_o.acc_load = 1'b1;
        cmd_o.mul_sel  = MUL_CA2;
        cmd_o.prod_en  = 1'b1;
        state_d = ST_CACC;
      end
      ST_CACC: begin
        cmd_o.acc_add = 1'b1;
        state_d = ST_CPREP;
      end
      ST_CB: begin
        cmd_o.mul_sel = MUL_CB;
        cmd_o.prod_en = 1'b1;
        state_d = ST_CBLD;
      end
      ST_CBLD: begin
        cmd_o.acc_load = 1'b1;
        state_d = ST_CPREP;
      end
      ST_CPREP: begin
        cmd_o.curve_prep = 1'b1;
        state_d = ST_CGO;
      end
      ST_CGO: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_CWAIT;
      end
      ST_CWAIT: if (status_i.div_done) state_d = ST_CDONE;
      ST_CDONE: begin
        cmd_o.b_we  = 1'b1;
        cmd_o.b_src = B_FROM_QUOT;
        state_d = ST_FMUL;
      end
      ST_FMUL: begin
        cmd_o.mul_sel = MUL_FORCE;
        cmd_o.prod_en = 1'b1;
        state_d = ST_FSAT;
      end
      ST_FSAT: begin
        cmd_o.force_we = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    if (advance) begin
      if (tbl_q == TBL_SAT) begin
        state_d = ST_CSEL;
      end else begin
        tbl_d   = tbl_q + 2'd1;
        k_d     = '0;
        state_d = ST_SCAN_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tbl_q   <= TBL_CLOUD;
      k_q     <= '0;
      seg_b_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tbl_q   <= tbl_d;
      k_q     <= k_d;
      seg_b_q <= seg_b_d;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_EMIT);

endmodule

// File: design/buoyancy_profile_evaluator_top.sv
// Top level of the buoyancy profile evaluator: register port, controller and datapath.
// A load transaction writes its knot (none for table_select 3) in the cycle it is
// accepted and leaves busy low. An evaluate transaction keeps busy high until its
// result strobe. Its run time is set by the knot scan through the single read port of
// the knot memory and by the 32-step radix-2 divider, which is shared by the three
// interpolations and the buoyancy curve. With any knot count at zero the result strobe
// comes in the cycle right after acceptance with table_empty set.
// The result is shown for one cycle only and the receiver cannot hold it off.
module buoyancy_profile_evaluator_top import bpe_pkg::*; #(
  parameter int TABLE_POINTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  bpe_in_t     in_item_i,
  output logic        result_valid_o,
  output bpe_out_t    result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(NUM_TABLES * TABLE_POINTS);

  logic signed [31:0] force_factor_q;
  logic [COUNT_W-1:0] cloud_count_q, mix_count_q, sat_count_q;
  logic               reg_we;
  bpe_cmd_t           cmd;
  bpe_status_t        status;
  logic [AW-1:0]      rd_addr;

  assign pready = 1'b1;
  assign reg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_factor_q <= FORCE_FACTOR_RESET;
      cloud_count_q  <= '0;
      mix_count_q    <= '0;
      sat_count_q    <= '0;
    end else if (reg_we) begin
      unique case (paddr[3:2])
        REG_FORCE_FACTOR: force_factor_q <= pwdata;
        REG_CLOUD_COUNT:  cloud_count_q  <= pwdata[COUNT_W-1:0];
        REG_MIX_COUNT:    mix_count_q    <= pwdata[COUNT_W-1:0];
        REG_SAT_COUNT:    sat_count_q    <= pwdata[COUNT_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FORCE_FACTOR: prdata = force_factor_q;
      REG_CLOUD_COUNT:  prdata = 32'(cloud_count_q);
      REG_MIX_COUNT:    prdata = 32'(mix_count_q);
      REG_SAT_COUNT:    prdata = 32'(sat_count_q);
      default:          prdata = '0;
    endcase
  end

  bpe_ctrl #(
    .TABLE_POINTS (TABLE_POINTS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .in_cmd_i       (in_item_i.cmd),
    .cloud_count_i  (cloud_count_q),
    .mix_count_i    (mix_count_q),
    .sat_count_i    (sat_count_q),
    .status_i       (status),
    .cmd_o          (cmd),
    .rd_addr_o      (rd_addr),
    .busy_o         (busy),
    .result_valid_o (result_valid_o)
  );

  bpe_datapath #(
    .TABLE_POINTS (TABLE_POINTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .rd_addr_i      (rd_addr),
    .in_item_i      (in_item_i),
    .force_factor_i (force_factor_q),
    .status_o       (status),
    .result_o       (result_o)
  );

endmodule

// File: design/bpe_checker.sv
// Port-level checker for the buoyancy profile evaluator, bound to the top level.
`include "buoyancy_profile_evaluator_top_assert.svh"

module bpe_port_checker import bpe_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input bpe_in_t  in_item_i,
  input logic     result_valid_o,
  input bpe_out_t result_o
);

  logic accept;
  logic is_eval;

  assign accept  = start && !busy;
  assign is_eval = (in_item_i.cmd == CMD_EVAL);

  `BPE_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !result_valid_o, "Result during reset")
  `BPE_ASSERT(a_result_while_busy, result_valid_o |-> busy, "Result strobe while not busy")
  `BPE_ASSERT(a_free_after_result, result_valid_o |=> !busy && !result_valid_o, "Not idle")
  `BPE_ASSERT(a_eval_goes_busy, accept && is_eval |=> busy, "Evaluate did not start")
  `BPE_ASSERT(a_load_no_busy, accept && !is_eval |=> !busy, "Load left block busy")

endmodule

bind buoyancy_profile_evaluator_top bpe_port_checker u_bpe_checker (.*);

// File: verif/bpe_checker.sv
`timescale 1ns / 100ps
// Checker for the buoyancy profile evaluator: predicts every result and compares it.
module bpe_checker import bpe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  bpe_in_t     in_item_i,
  input  logic        result_valid_o,
  input  bpe_out_t    result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending_count
);

  localparam int KNOTS = 16;
  localparam longint Q_ONE = 65536;

  logic signed [31:0] knot_h [NUM_TABLES*KNOTS];
  logic signed [31:0] knot_v [NUM_TABLES*KNOTS];
  logic signed [31:0] force_factor;
  logic [4:0]         knot_count [NUM_TABLES];
  bpe_out_t           expected_results [$];

  assign pending_count = expected_results.size();

  function automatic longint interp_table(int t, longint x);
    int n;
    int i;
    int b;
    longint x0;
    longint x1;
    longint y0;
    longint y1;
    longint dy;
    longint ady;
    logic [127:0] prod;
    longint mag;
    n = (knot_count[t] > KNOTS) ? KNOTS : int'(knot_count[t]);
    b = t * KNOTS;
    i = 0;
    while (i < n && longint'(knot_h[b+i]) <= x) i++;
    if (i == 0) return longint'(knot_v[b]);
    if (i >= n) return longint'(knot_v[b+n-1]);
    x0 = knot_h[b+i-1];
    x1 = knot_h[b+i];
    y0 = knot_v[b+i-1];
    y1 = knot_v[b+i];
    if (!(x0 < x1)) return y0;
    dy = y1 - y0;
    ady = (dy < 0) ? -dy : dy;
    prod = (128'(ady) * 128'(x - x0)) / 128'(x1 - x0);
    mag = longint'(prod[63:0]);
    return (dy < 0) ? y0 - mag : y0 + mag;
  endfunction

  function automatic longint curve_buoyancy(longint c, longint bc, longint chis, longint bs);
    longint den;
    if (c <= 0) return bc;
    if (c >= Q_ONE) return 0;
    if (c < chis) return (bc * (chis - c) + bs * c) / chis;
    den = Q_ONE - chis;
    if (den <= 0) return bs / 2;
    return (bs * (Q_ONE - c)) / den;
  endfunction

  function automatic bpe_out_t predict_buoyancy(bpe_in_t it);
    bpe_out_t r;
    longint x;
    longint c;
    longint b;
    longint f;
    r = '0;
    if (knot_count[0] == 0 || knot_count[1] == 0 || knot_count[2] == 0) begin
      r.table_empty = 1'b1;
      return r;
    end
    x = it.cell_height;
    c = it.tracer_fraction;
    if (c < 0) c = 0;
    if (c > Q_ONE) c = Q_ONE;
    b = curve_buoyancy(c, interp_table(0, x), interp_table(1, x), interp_table(2, x));
    f = (b * longint'(force_factor)) / Q_ONE;
    if (f > 64'sh7fffffff) f = 64'sh7fffffff;
    if (f < -64'sh80000000) f = -64'sh80000000;
    r.buoyancy = b[31:0];
    r.force_increment = f[31:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bpe_out_t exp_r;
    int p;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      force_factor <= FORCE_FACTOR_RESET;
      for (int t = 0; t < NUM_TABLES; t++) knot_count[t] <= '0;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (result_valid_o) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, result_o);
          errs++;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.buoyancy !== result_o.buoyancy) begin
            $display("%0t: buoyancy mismatch, expected %h, actual %h", $time,
                     exp_r.buoyancy, result_o.buoyancy);
            errs++;
          end
          if (exp_r.force_increment !== result_o.force_increment) begin
            $display("%0t: force_increment mismatch, expected %h, actual %h", $time,
                     exp_r.force_increment, result_o.force_increment);
            errs++;
          end
          if (exp_r.table_empty !== result_o.table_empty) begin
            $display("%0t: table_empty mismatch, expected %b, actual %b", $time,
                     exp_r.table_empty, result_o.table_empty);
            errs++;
          end
        end
      end
      if (errs != 0) begin
        fail_count <= fail_count + errs;
      end
      if (start && !busy) begin
        if (in_item_i.cmd == CMD_EVAL) begin
          expected_results.push_back(predict_buoyancy(in_item_i));
        end else if (in_item_i.table_select != 2'd3) begin
          p = int'(in_item_i.table_select) * KNOTS + int'(in_item_i.knot_index);
          knot_h[p] <= in_item_i.knot_height;
          knot_v[p] <= in_item_i.knot_value;
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_FORCE_FACTOR: force_factor <= pwdata;
          REG_CLOUD_COUNT:  knot_count[0] <= pwdata[4:0];
          REG_MIX_COUNT:    knot_count[1] <= pwdata[4:0];
          REG_SAT_COUNT:    knot_count[2] <= pwdata[4:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: verif/tb_buoyancy_profile_evaluator_top.sv
`timescale 1ns / 100ps
// Testbench top for the buoyancy profile evaluator: stimulus, register writes and verdict.
module tb_buoyancy_profile_evaluator_top import bpe_pkg::*; ();

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  bpe_in_t     in_item_i;
  logic        result_valid_o;
  bpe_out_t    result_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending_count;
  int          idle_pct;
  bit          drain_each;

  buoyancy_profile_evaluator_top dut (
    .clk_i, .rst_ni, .start, .busy, .in_item_i, .result_valid_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  bpe_checker checker_i (
    .clk_i, .rst_ni, .start, .busy, .in_item_i, .result_valid_o, .result_o,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .fail_count, .pending_count
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #10000000;
    $display("status: fail");
    $finish;
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0 || busy) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_config(logic [31:0] ff, logic [4:0] nc, logic [4:0] nm, logic [4:0] ns);
    wait_idle();
    reg_write(REG_FORCE_FACTOR, ff);
    reg_write(REG_CLOUD_COUNT, {27'd0, nc});
    reg_write(REG_MIX_COUNT, {27'd0, nm});
    reg_write(REG_SAT_COUNT, {27'd0, ns});
  endtask

  task automatic send(bpe_in_t it);
    in_item_i <= it;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    if (drain_each) begin
      start <= 1'b0;
      @(posedge clk_i);
      while (pending_count != 0 || busy) @(posedge clk_i);
    end else if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic bpe_in_t load_item(logic [1:0] sel, logic [3:0] idx,
                                        logic [31:0] h, logic [31:0] v);
    bpe_in_t it;
    it = bpe_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.cmd = CMD_LOAD;
    it.table_select = sel;
    it.knot_index = idx;
    it.knot_height = h;
    it.knot_value = v;
    return it;
  endfunction

  function automatic bpe_in_t eval_item(logic [31:0] x, logic [31:0] c);
    bpe_in_t it;
    it = bpe_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.cmd = CMD_EVAL;
    it.cell_height = x;
    it.tracer_fraction = c;
    return it;
  endfunction

  function automatic logic [31:0] sorted_height(int k);
    return 32'((k - 8) * 134217728 + int'($urandom_range(0, 120000000)));
  endfunction

  function automatic logic [31:0] rand_value(logic [1:0] sel);
    case ($urandom_range(3))
      0: return $urandom;
      1: return (sel == TBL_MIX) ? 32'($urandom_range(0, 65536)) : 32'h7fffffff;
      2: return (sel == TBL_MIX) ? 32'($urandom_range(0, 65536)) : 32'h80000000;
      default: return 32'($signed($urandom) >>> 8);
    endcase
  endfunction

  function automatic logic [31:0] rand_tracer();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'($urandom_range(0, 65536));
      2: return 32'($urandom_range(0, 65536));
      3: return 32'(-int'($urandom_range(1, 1000)));
      default: return 32'(65536 + $urandom_range(0, 1000));
    endcase
  endfunction

  function automatic bpe_in_t rand_item();
    logic [1:0] sel;
    logic [3:0] idx;
    sel = 2'($urandom_range(3));
    idx = 4'($urandom);
    if ($urandom_range(99) < 35) begin
      return load_item(sel, idx, ($urandom_range(3) == 0) ? $urandom : sorted_height(idx),
                       rand_value(sel));
    end
    return eval_item(($urandom_range(3) == 0) ? $urandom : 32'($signed($urandom) >>> 1),
                     rand_tracer());
  endfunction

  initial begin
    logic [31:0] ff_set [8];
    logic [4:0]  cnt_set [8][3];
    rst_ni    = 1'b0;
    start     = 1'b0;
    in_item_i = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    idle_pct  = 0;
    drain_each = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(eval_item(32'h0, 32'h8000));
    for (int t = 0; t < NUM_TABLES; t++) begin
      for (int k = 0; k < 16; k++) begin
        send(load_item(2'(t), 4'(k), sorted_height(k), rand_value(2'(t))));
      end
    end
    send(load_item(2'd3, 4'hf, 32'h7fffffff, 32'h80000000));
    set_config(FORCE_FACTOR_RESET, 5'd16, 5'd16, 5'd16);
    send(eval_item(32'h80000000, 32'h80000000));
    send(eval_item(32'h7fffffff, 32'h7fffffff));
    send(eval_item(32'h0, 32'h0));
    send(eval_item(32'h0, 32'h10000));
    send(eval_item(32'h100, 32'h8000));
    send(eval_item(32'hf0000000, 32'h4000));
    send(eval_item(32'h10000000, 32'hc000));
    send(load_item(TBL_CLOUD, 4'd5, 32'h0, 32'h7fffffff));
    send(load_item(TBL_CLOUD, 4'd6, 32'h0, 32'h80000000));
    send(eval_item(32'h0, 32'h1));
    send(eval_item(32'hffffffff, 32'hffff));

    ff_set = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h00010000,
               $urandom, 32'h00020000, $urandom, 32'hffff0000};
    cnt_set = '{'{5'd16, 5'd16, 5'd16}, '{5'd1, 5'd1, 5'd1}, '{5'd31, 5'd20, 5'd17},
                '{5'd0, 5'd5, 5'd5}, '{5'd2, 5'd9, 5'd16}, '{5'd16, 5'd0, 5'd3},
                '{5'd4, 5'd16, 5'd0}, '{5'd12, 5'd7, 5'd16}};
    for (int ph = 0; ph < 8; ph++) begin
      set_config(ff_set[ph], cnt_set[ph][0], cnt_set[ph][1], cnt_set[ph][2]);
      idle_pct = (ph % 4 == 1) ? 63 : (ph % 4 == 3) ? 34 : 0;
      drain_each = (ph == 2);
      for (int n = 0; n < 125; n++) send(rand_item());
      drain_each = 1'b0;
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/bpe_pkg.sv
design/bpe_divider.sv
design/bpe_datapath.sv
design/bpe_ctrl.sv
design/buoyancy_profile_evaluator_top.sv
design/bpe_checker.sv
verif/bpe_checker.sv
verif/tb_buoyancy_profile_evaluator_top.sv
